@@ design/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and byte encoding helpers shared by the transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // Upper six bits of a surrogate code unit.
  localparam logic [5:0]  HighSurrTag    = 6'h36;
  localparam logic [5:0]  LowSurrTag     = 6'h37;
  localparam logic [20:0] CpReplacement  = 21'h00FFFD;
  // Added to the high surrogate payload before it is shifted up ten bits.
  localparam logic [10:0] SuppPlaneBias  = 11'd64;
  localparam int unsigned QueueDepth     = 2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       text_last;
  } out_beat_t;

  // One queued job: an optional replacement character for a dropped high
  // surrogate, then an optional code point of the current unit.
  typedef struct packed {
    logic        prefix_fffd;
    logic        has_cp;
    logic [20:0] code_point;
    logic        text_end;
  } job_t;

  // Number of UTF-8 bytes minus one.
  function automatic logic [1:0] cp_len_m1(input logic [20:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) begin
      r = 2'd0;
    end else if (cp < 21'h800) begin
      r = 2'd1;
    end else if (cp < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                          input logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] sh;
    sh = len_m1 - idx;
    if (idx == 2'd0) begin
      unique case (len_m1)
        2'd0: b = {1'b0, cp[6:0]};
        2'd1: b = {3'b110, cp[10:6]};
        2'd2: b = {4'b1110, cp[15:12]};
        2'd3: b = {5'b11110, cp[20:18]};
        default: b = 8'h00;
      endcase
    end else begin
      unique case (sh)
        2'd0: b = {2'b10, cp[5:0]};
        2'd1: b = {2'b10, cp[11:6]};
        2'd2: b = {2'b10, cp[17:12]};
        default: b = {5'b10000, cp[20:18]};
      endcase
    end
    return b;
  endfunction

endpackage

@@ design/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and issues encoding jobs.
// ----------------------------------------------------------------------------
module u16u8_front import u16u8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t beat_i,
  output logic     push_o,
  output job_t     job_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       is_high, is_low, pair;

  always_comb begin
    is_high = (beat_i.code_unit[15:10] == HighSurrTag);
    is_low  = (beat_i.code_unit[15:10] == LowSurrTag);
    pair    = held_valid_q && is_low;

    job_o.prefix_fffd = held_valid_q && !is_low;
    job_o.has_cp      = pair || !(is_high && !beat_i.string_end);
    job_o.text_end    = beat_i.string_end;
    if (pair) begin
      job_o.code_point = {{1'b0, held_bits_q} + SuppPlaneBias, beat_i.code_unit[9:0]};
    end else if (is_high || is_low) begin
      job_o.code_point = CpReplacement;
    end else begin
      job_o.code_point = {5'd0, beat_i.code_unit};
    end

    // A beat that only parks a high surrogate produces no job.
    push_o = accept_i && (job_o.prefix_fffd || job_o.has_cp);

    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    if (accept_i) begin
      held_valid_d = is_high && !beat_i.string_end;
      held_bits_d  = beat_i.code_unit[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q  <= held_bits_d;
    end
  end

endmodule

@@ design/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
module u16u8_queue import u16u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ design/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued jobs into UTF-8 bytes behind an output register.
// ----------------------------------------------------------------------------
module u16u8_back import u16u8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  job_t       rec_q, rec_d;
  logic       busy_q, busy_d;
  logic       pre_q, pre_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;

  logic [20:0] cur_cp;
  logic [1:0]  len_m1;
  logic        out_free, fire, last_of_cp, last_of_rec;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cur_cp      = pre_q ? CpReplacement : rec_q.code_point;
    len_m1      = cp_len_m1(cur_cp);
    out_free    = !out_valid_q || !out_stall_i;
    fire        = busy_q && out_free;
    last_of_cp  = (idx_q == len_m1);
    last_of_rec = last_of_cp && (!pre_q || !rec_q.has_cp);
    // Load the next job on the cycle the last byte of this one goes out.
    pop_o       = !empty_i && (!busy_q || (fire && last_of_rec));

    rec_d       = rec_q;
    busy_d      = busy_q;
    pre_d       = pre_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_free) begin
      out_valid_d = fire;
    end
    if (fire) begin
      out_d.utf8_byte = enc_byte(cur_cp, len_m1, idx_q);
      out_d.run_last  = last_of_rec;
      out_d.text_last = last_of_rec && rec_q.text_end;
      if (!last_of_cp) begin
        idx_d = idx_q + 1'b1;
      end else if (!last_of_rec) begin
        pre_d = 1'b0;
        idx_d = '0;
      end else begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      rec_d  = job_i;
      busy_d = 1'b1;
      pre_d  = job_i.prefix_fffd;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pre_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pre_q       <= pre_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    out_q <= out_d;
  end

endmodule

@@ design/utf16_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of UTF-16 code units into a byte stream of UTF-8.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_beat_t  (code_unit, string_end)
//  out     | output    | out_valid_o / out_stall_i| out_beat_t (utf8_byte, run_last,
//          |           |                          |             text_last)
//
// Bytes leave through a byte serializer that a stalled output holds; a unit
// yields one to four bytes (none when it only parks a high surrogate, up to six
// when a dropped high surrogate is replaced first), and that serializer sets the
// sustained rate. A two-job queue lets units enter while bytes drain. Reset
// clears the held surrogate, the queue and the output register. A stalled
// output holds its byte; the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder import u16u8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic accept, push, pop, q_empty, q_full;
  job_t front_job, head_job;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  u16u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_data_i),
    .push_o   (push),
    .job_o    (front_job)
  );

  u16u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/utf16_to_utf8_transcoder_tb.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. Code units are sent
// one beat at a time while an independent transcoder model predicts every
// UTF-8 byte with its run and text end flags. Output beats are compared in
// order. Random gaps on the input side and random stalls on the output side
// vary the timing. A long output hold-off fills the block, and a pause on
// the input side lets it drain.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;
  import u16u8_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned RandomUnits   = 390;

  localparam logic [15:0] HighSurrFirst = 16'hD800;
  localparam logic [15:0] HighSurrLast  = 16'hDBFF;
  localparam logic [15:0] LowSurrFirst  = 16'hDC00;
  localparam logic [15:0] LowSurrLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase      = 21'h10000;
  localparam logic [20:0] ReplacementCp = 21'h00FFFD;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  utf16_to_utf8_transcoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Model state: a high surrogate that waits for its low half.
  logic        pend_high_valid;
  logic [9:0]  pend_high_bits;

  logic [7:0]  unit_bytes[$];
  out_beat_t   expected_utf8[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned units_sent;
  bit          tx_idle_en;

  // Output stall control. The hold-off request is a counter so that, past its
  // initial value, only the stall process writes the hold-off length.
  bit          rx_idle_en;
  int unsigned holdoff_req;
  int unsigned holdoff_ack;
  int unsigned holdoff_left;
  int unsigned stall_left;
  int unsigned flow_left;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void utf8_append(input logic [20:0] cp);
    if (cp < 21'h80) begin
      unit_bytes.insert(unit_bytes.size(), {1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      unit_bytes.insert(unit_bytes.size(), {3'b110, cp[10:6]});
      unit_bytes.insert(unit_bytes.size(), {2'b10, cp[5:0]});
    end else if (cp < SuppBase) begin
      unit_bytes.insert(unit_bytes.size(), {4'b1110, cp[15:12]});
      unit_bytes.insert(unit_bytes.size(), {2'b10, cp[11:6]});
      unit_bytes.insert(unit_bytes.size(), {2'b10, cp[5:0]});
    end else begin
      unit_bytes.insert(unit_bytes.size(), {5'b11110, cp[20:18]});
      unit_bytes.insert(unit_bytes.size(), {2'b10, cp[17:12]});
      unit_bytes.insert(unit_bytes.size(), {2'b10, cp[11:6]});
      unit_bytes.insert(unit_bytes.size(), {2'b10, cp[5:0]});
    end
  endfunction

  // Works out the bytes that one accepted code unit completes.
  function automatic void transcode_unit(input in_beat_t beat);
    logic      is_high;
    logic      is_low;
    out_beat_t ob;
    is_high = (beat.code_unit >= HighSurrFirst) && (beat.code_unit <= HighSurrLast);
    is_low  = (beat.code_unit >= LowSurrFirst) && (beat.code_unit <= LowSurrLast);
    unit_bytes.delete();
    if (pend_high_valid && is_low) begin
      utf8_append(SuppBase + {1'b0, pend_high_bits, beat.code_unit[9:0]});
      pend_high_valid = 1'b0;
      pend_high_bits  = '0;
    end else begin
      // A waiting high surrogate without its low half is replaced first.
      if (pend_high_valid) begin
        utf8_append(ReplacementCp);
        pend_high_valid = 1'b0;
        pend_high_bits  = '0;
      end
      if (is_high && !beat.string_end) begin
        pend_high_bits  = beat.code_unit[9:0];
        pend_high_valid = 1'b1;
      end else if (is_high || is_low) begin
        utf8_append(ReplacementCp);
      end else begin
        utf8_append({5'd0, beat.code_unit});
      end
    end
    foreach (unit_bytes[k]) begin
      ob.utf8_byte = unit_bytes[k];
      ob.run_last  = (k == unit_bytes.size() - 1);
      ob.text_last = ob.run_last && beat.string_end;
      expected_utf8.insert(expected_utf8.size(), ob);
    end
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  // Valid stays high afterwards so that a following beat can go out at once.
  task automatic send_unit(input logic [15:0] cu, input logic last);
    in_beat_t    beat;
    int unsigned gap;
    beat.code_unit  = cu;
    beat.string_end = last;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    transcode_unit(beat);
    units_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_utf8.size() != 0);
  endtask

  task automatic send_random_string(input int unsigned len);
    int unsigned i;
    int unsigned kind;
    logic [15:0] cu;
    i = 0;
    while (i < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        send_unit(16'($urandom_range(0, 16'h007F)), i == len - 1);
      end else if (kind < 35) begin
        send_unit(16'($urandom_range(16'h0080, 16'h07FF)), i == len - 1);
      end else if (kind < 55 || (kind < 85 && i == len - 1)) begin
        cu = 16'($urandom_range(16'h0800, 16'hF7FF));
        if (cu >= HighSurrFirst) begin
          cu = cu + 16'h0800;
        end
        send_unit(cu, i == len - 1);
      end else if (kind < 85) begin
        send_unit(16'($urandom_range(HighSurrFirst, HighSurrLast)), 1'b0);
        i++;
        send_unit(16'($urandom_range(LowSurrFirst, LowSurrLast)), i == len - 1);
      end else if (kind < 92) begin
        // Broken pair: a high surrogate followed by anything at all.
        send_unit(16'($urandom_range(HighSurrFirst, HighSurrLast)), i == len - 1);
        if (i != len - 1) begin
          i++;
          send_unit(16'($urandom_range(0, 16'hFFFF)), i == len - 1);
        end
      end else begin
        send_unit(16'($urandom_range(0, 16'hFFFF)), i == len - 1);
      end
      i++;
    end
  endtask

  task automatic test_directed_units();
    send_unit(16'h0000, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFD, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // Lowest and highest surrogate pairs.
    send_unit(HighSurrFirst, 1'b0);
    send_unit(LowSurrFirst, 1'b0);
    send_unit(HighSurrLast, 1'b0);
    send_unit(LowSurrLast, 1'b1);
    // Lone low surrogate, then a high surrogate as the last unit.
    send_unit(LowSurrFirst, 1'b0);
    send_unit(HighSurrLast, 1'b1);
    // A held high surrogate dropped by an ASCII unit.
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0041, 1'b0);
    // Dropped by a three byte unit: six bytes from one beat.
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    // Dropped by another high surrogate that then pairs up.
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBC0, 1'b0);
    send_unit(16'hDE01, 1'b0);
    // Dropped by a high surrogate that ends the string.
    send_unit(16'hD801, 1'b0);
    send_unit(16'hD802, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_strings();
    int unsigned stop_at;
    stop_at = units_sent + RandomUnits;
    while (units_sent < stop_at) begin
      send_random_string($urandom_range(1, 8));
    end
  endtask

  // The receiver holds off for a long stretch while units keep coming, so
  // the job queue fills and the input stalls.
  task automatic test_output_holdoff();
    tx_idle_en = 1'b0;
    holdoff_req <= holdoff_req + 1;
    repeat (4) begin
      send_random_string($urandom_range(4, 8));
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    send_random_string(6);
    send_unit(16'hDBFF, 1'b0);
    wait_for_drain();
    // The surrogate is still held across the pause and must pair up now.
    send_unit(16'hDC00, 1'b1);
    wait_for_drain();
    send_random_string(6);
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (6) begin
      send_random_string($urandom_range(4, 8));
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= HoldOffCycles;
      out_stall_i  <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall_i  <= 1'b1;
    end else if (!rx_idle_en) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (flow_left != 0) begin
      flow_left   <= flow_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
      flow_left   <= $urandom_range(0, 12);
      stall_left  <= pick_gap();
    end
  end

  // Each accepted output beat is checked against the oldest expected byte.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_utf8.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat, actual byte=%02h run_last=%b text_last=%b",
                 $time, out_data_o.utf8_byte, out_data_o.run_last, out_data_o.text_last);
      end else begin
        want = expected_utf8.pop_front();
        if (out_data_o.utf8_byte !== want.utf8_byte) begin
          error_count++;
          $display("%0t: utf8_byte mismatch, expected=%02h actual=%02h",
                   $time, want.utf8_byte, out_data_o.utf8_byte);
        end
        if (out_data_o.run_last !== want.run_last) begin
          error_count++;
          $display("%0t: run_last mismatch, expected=%b actual=%b",
                   $time, want.run_last, out_data_o.run_last);
        end
        if (out_data_o.text_last !== want.text_last) begin
          error_count++;
          $display("%0t: text_last mismatch, expected=%b actual=%b",
                   $time, want.text_last, out_data_o.text_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("utf16_to_utf8_transcoder regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_stall_i     = 1'b0;
    pend_high_valid = 1'b0;
    pend_high_bits  = '0;
    error_count     = 0;
    cycle_count     = 0;
    units_sent      = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    holdoff_req     = 0;
    holdoff_ack     = 0;
    holdoff_left    = 0;
    stall_left      = 0;
    flow_left       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_units();
    test_random_strings();
    test_output_holdoff();
    test_pause_until_drained();
    test_back_to_back();

    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("utf16_to_utf8_transcoder regression: pass");
    end else begin
      $display("utf16_to_utf8_transcoder regression: fail");
    end
    $finish;
  end

endmodule
